@@ src/pba_pkg.sv @@
// Shared types, register indexes and codes of the paged bump allocator.
package pba_pkg;

    // Number of page slots that have a size register.
    localparam int unsigned SIZE_REGS = 4;
    // Default number of page slots in the state.
    localparam int unsigned DEF_MAX_PAGES = 4;

    // Configuration port geometry: six 32-bit registers at 4*i.
    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_PAGE_COUNT  = 3'd0;
    localparam logic [2:0] REG_PAGE_SIZE_0 = 3'd1;
    localparam logic [2:0] REG_PAGE_SIZE_1 = 3'd2;
    localparam logic [2:0] REG_PAGE_SIZE_2 = 3'd3;
    localparam logic [2:0] REG_PAGE_SIZE_3 = 3'd4;
    localparam logic [2:0] REG_AREA_SIZE   = 3'd5;

    typedef logic [2:0]  t_count;
    typedef logic [29:0] t_size;
    typedef logic [31:0] t_word;
    typedef logic [7:0]  t_page_idx;

    // Command codes.
    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_BAD_PAGE = 2'd2,
        ST_NO_MEM   = 2'd3
    } t_status;

    // Current register contents handed to the command engine.
    typedef struct packed {
        t_count                      page_count;
        logic [SIZE_REGS-1:0][29:0]  page_size;
        t_word                       area_size;
        logic                        reinit;
    } t_cfg;

endpackage

@@ src/pba_cmd_if.sv @@
// Command channel: valid/ready handshake carrying one allocator command word.
interface pba_cmd_if;
    import pba_pkg::*;

    logic      valid;
    logic      ready;
    logic      command;
    t_word     amount;
    t_page_idx page_index;

    modport source (output valid, command, amount, page_index, input ready);
    modport sink   (input valid, command, amount, page_index, output ready);
endinterface

@@ src/pba_rsp_if.sv @@
// Result channel: valid/ready handshake carrying one allocator result word.
interface pba_rsp_if;
    import pba_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_word   page_offset_now;
    t_size   page_free_now;
    t_word   area_free_now;

    modport source (output valid, status, page_offset_now, page_free_now, area_free_now,
                    input ready);
    modport sink   (input valid, status, page_offset_now, page_free_now, area_free_now,
                    output ready);
endinterface

@@ src/pba_cfg_regs.sv @@
// APB-style register file of the allocator; flags a state reload after every write to a defined register.
module pba_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pba_pkg::PADDR_W-1:0]     paddr,
    input  logic [pba_pkg::PDATA_W-1:0]     pwdata,
    output logic [pba_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    output pba_pkg::t_cfg                   o_cfg
);
    import pba_pkg::*;

    logic                         r_reinit;
    t_count                       r_page_count;
    logic [SIZE_REGS-1:0][29:0]   r_page_size;
    t_word                        r_area_size;
    logic                         wr_en;
    logic [2:0]                   reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes; a write to a defined register requests a reload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= 3'd1;
            r_page_size  <= '0;
            r_area_size  <= '0;
            r_reinit     <= 1'b0;
        end else begin
            r_reinit <= 1'b0;
            if (wr_en) begin
                case (reg_idx)
                    REG_PAGE_COUNT: begin
                        r_page_count <= pwdata[2:0];
                        r_reinit     <= 1'b1;
                    end
                    REG_PAGE_SIZE_0: begin
                        r_page_size[0] <= pwdata[29:0];
                        r_reinit       <= 1'b1;
                    end
                    REG_PAGE_SIZE_1: begin
                        r_page_size[1] <= pwdata[29:0];
                        r_reinit       <= 1'b1;
                    end
                    REG_PAGE_SIZE_2: begin
                        r_page_size[2] <= pwdata[29:0];
                        r_reinit       <= 1'b1;
                    end
                    REG_PAGE_SIZE_3: begin
                        r_page_size[3] <= pwdata[29:0];
                        r_reinit       <= 1'b1;
                    end
                    REG_AREA_SIZE: begin
                        r_area_size <= pwdata;
                        r_reinit    <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Read data mux.
    always_comb begin
        case (reg_idx)
            REG_PAGE_COUNT:  prdata = {29'd0, r_page_count};
            REG_PAGE_SIZE_0: prdata = {2'd0, r_page_size[0]};
            REG_PAGE_SIZE_1: prdata = {2'd0, r_page_size[1]};
            REG_PAGE_SIZE_2: prdata = {2'd0, r_page_size[2]};
            REG_PAGE_SIZE_3: prdata = {2'd0, r_page_size[3]};
            REG_AREA_SIZE:   prdata = r_area_size;
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.page_count = r_page_count;
        o_cfg.page_size  = r_page_size;
        o_cfg.area_size  = r_area_size;
        o_cfg.reinit     = r_reinit;
    end

endmodule

@@ src/pba_engine.sv @@
// Command engine: input register, page state, single-pass check and update, result register.
module pba_engine #(
    parameter int unsigned MAX_PAGES = pba_pkg::DEF_MAX_PAGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pba_pkg::t_cfg    i_cfg,
    pba_cmd_if.sink          i_cmd,
    pba_rsp_if.source        o_rsp
);
    import pba_pkg::*;

    localparam int unsigned IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam t_page_idx   MAX_P = t_page_idx'(MAX_PAGES);

    // Pipeline control.
    logic       r_in_valid;
    logic       r_out_valid;
    logic       advance;
    logic       in_ready;

    // Input register.
    logic       r_cmd;
    t_word      r_amount;
    t_page_idx  r_idx;

    // Page and area state.
    t_size      r_page_free   [MAX_PAGES];
    t_word      r_page_cursor [MAX_PAGES];
    t_word      r_area_free;

    // Result register.
    t_status    r_status;
    t_word      r_offset;
    t_size      r_free;
    t_word      r_area;

    // Combinational datapath.
    t_page_idx       eff_count;
    logic            idx_valid;
    logic [IDX_W-1:0] sel;
    t_size           cur_free;
    t_word           cur_cursor;
    t_size           cur_size;
    logic [32:0]     area_sum;
    logic [32:0]     page_sum;
    t_status         status_c;
    t_size           new_free;
    t_word           new_cursor;
    t_word           new_area;
    logic            commit;

    // Reload values: page start offsets are prefix sums of the page sizes.
    t_word           prefix [SIZE_REGS+1];
    t_word           sum_23;
    t_size           init_free   [MAX_PAGES];
    t_word           init_cursor [MAX_PAGES];

    assign advance     = !r_out_valid || o_rsp.ready;
    assign in_ready    = !r_in_valid || advance;
    assign i_cmd.ready = in_ready;

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.page_offset_now = r_offset;
    assign o_rsp.page_free_now   = r_free;
    assign o_rsp.area_free_now   = r_area;

    // Prefix sums arranged as a two-level adder tree.
    always_comb begin
        prefix[0] = '0;
        prefix[1] = {2'd0, i_cfg.page_size[0]};
        prefix[2] = {2'd0, i_cfg.page_size[0]} + {2'd0, i_cfg.page_size[1]};
        prefix[3] = prefix[2] + {2'd0, i_cfg.page_size[2]};
        sum_23    = {2'd0, i_cfg.page_size[2]} + {2'd0, i_cfg.page_size[3]};
        prefix[4] = prefix[2] + sum_23;
        for (int i = 0; i < MAX_PAGES; i++) begin
            if (i < SIZE_REGS) begin
                init_free[i]   = i_cfg.page_size[i & 3];
                init_cursor[i] = prefix[i & 3];
            end else begin
                init_free[i]   = '0;
                init_cursor[i] = prefix[SIZE_REGS];
            end
        end
    end

    // Checks in priority order, then the new page and area values.
    always_comb begin
        if ({5'd0, i_cfg.page_count} > MAX_P) begin
            eff_count = MAX_P;
        end else begin
            eff_count = {5'd0, i_cfg.page_count};
        end
        idx_valid  = r_idx < eff_count;
        sel        = idx_valid ? r_idx[IDX_W-1:0] : '0;
        cur_free   = r_page_free[sel];
        cur_cursor = r_page_cursor[sel];
        cur_size   = (r_idx < 8'(SIZE_REGS)) ? i_cfg.page_size[r_idx[1:0]] : '0;
        area_sum   = {1'b0, r_area_free} + {1'b0, r_amount};
        page_sum   = {3'd0, cur_free} + {1'b0, r_amount};

        status_c   = ST_OK;
        new_free   = cur_free;
        new_cursor = cur_cursor;
        new_area   = r_area_free;

        if (r_amount == '0) begin
            status_c = ST_BAD_SIZE;
        end else if (!idx_valid) begin
            status_c = ST_BAD_PAGE;
        end else if (t_cmd'(r_cmd) == CMD_ALLOC) begin
            if (r_amount > r_area_free || r_amount > {2'd0, cur_free}) begin
                status_c = ST_NO_MEM;
            end else begin
                new_area   = r_area_free - r_amount;
                new_free   = cur_free - r_amount[29:0];
                new_cursor = cur_cursor + r_amount;
            end
        end else begin
            if (area_sum > {1'b0, i_cfg.area_size} || page_sum > {3'd0, cur_size}) begin
                status_c = ST_NO_MEM;
            end else begin
                new_area   = area_sum[31:0];
                new_free   = page_sum[29:0];
                new_cursor = cur_cursor - r_amount;
            end
        end

        commit = advance && r_in_valid && (status_c == ST_OK);
    end

    // Handshake state of the two register stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Input word capture.
    always_ff @(posedge i_clk) begin
        if (in_ready && i_cmd.valid) begin
            r_cmd    <= i_cmd.command;
            r_amount <= i_cmd.amount;
            r_idx    <= i_cmd.page_index;
        end
    end

    // Result word capture.
    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_status <= status_c;
            r_offset <= idx_valid ? new_cursor : '0;
            r_free   <= idx_valid ? new_free : '0;
            r_area   <= new_area;
        end
    end

    // Page and area state: cleared at reset, reloaded after a register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PAGES; i++) begin
                r_page_free[i]   <= '0;
                r_page_cursor[i] <= '0;
            end
            r_area_free <= '0;
        end else if (i_cfg.reinit) begin
            for (int i = 0; i < MAX_PAGES; i++) begin
                r_page_free[i]   <= init_free[i];
                r_page_cursor[i] <= init_cursor[i];
            end
            r_area_free <= i_cfg.area_size;
        end else if (commit) begin
            r_page_free[sel]   <= new_free;
            r_page_cursor[sel] <= new_cursor;
            r_area_free        <= new_area;
        end
    end

    // The shared budget never rises above the configured area size.
    a_area_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg.reinit |-> r_area_free <= i_cfg.area_size)
        else $error("area free count exceeds area size");

    // A bad page index reports a zero offset and zero free count.
    a_bad_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_BAD_PAGE) |-> (r_offset == '0 && r_free == '0))
        else $error("bad page result carries page data");

    // A failed command leaves the area budget untouched.
    a_fail_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && status_c != ST_OK && !i_cfg.reinit)
        |=> $stable(r_area_free))
        else $error("failed command changed the area budget");

    // A successful allocation takes exactly the amount from the area budget.
    a_alloc_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && t_cmd'(r_cmd) == CMD_ALLOC && !i_cfg.reinit)
        |=> r_area_free == $past(r_area_free) - $past(r_amount))
        else $error("allocation did not debit the area budget");

endmodule

@@ src/paged_bump_allocator.sv @@
// Top level of the paged bump allocator: register file and command engine.
//
// Usage: commands enter on i_cmd (command, amount, page_index) with a valid/ready
// handshake; one result word (status, page_offset_now, page_free_now, area_free_now)
// leaves on o_rsp for every command, in command order.
// An accepted command is held in the input register, then the check and state
// update are done in one pass into the result register. One command is taken per
// cycle while o_rsp does not stall; the page state is updated at the same edge
// that loads the result, so back-to-back commands on one page see each other's
// effect with no bubble.
// When o_rsp stalls, the result register holds its word and the input register
// keeps accepting until it is full; while it is full, i_cmd.ready follows o_rsp.ready.
// The APB port holds page_count, four page sizes and area_size at 4*i. Any write
// to a defined register reloads the page free counts, page start offsets and area
// budget in the next cycle. Writes must be done while no command is in flight;
// the block does not enforce this. Reset (synchronous, active low) sets page_count
// to one, all sizes to zero and clears the page state and both register stages.
module paged_bump_allocator #(
    parameter int unsigned MAX_PAGES = pba_pkg::DEF_MAX_PAGES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pba_pkg::PADDR_W-1:0]     paddr,
    input  logic [pba_pkg::PDATA_W-1:0]     pwdata,
    output logic [pba_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    pba_cmd_if.sink                         i_cmd,
    pba_rsp_if.source                       o_rsp
);
    import pba_pkg::*;

    t_cfg cfg;

    // Configuration registers.
    pba_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Command processing.
    pba_engine #(
        .MAX_PAGES (MAX_PAGES)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (i_cmd),
        .o_rsp   (o_rsp)
    );

endmodule
